// ----- rtl/audio_capture_statistics_macros.svh -----
// Assertion helpers shared by the RTL files.
// Every assertion is clocked on i_clk and held off while i_rst_n is low.
`ifndef AUDIO_CAPTURE_STATISTICS_MACROS_SVH
`define AUDIO_CAPTURE_STATISTICS_MACROS_SVH

// Condition that must hold at every clock edge
`define ACS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition that must hold at every edge where the precondition is true
`define ACS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- rtl/acs_pkg.sv -----
package acs_pkg;

    // Field and datapath widths
    localparam int SMP_W     = 16;             // sample field width
    localparam int N_W       = 21;             // samples per tick, quotient width
    localparam int ACC_W     = 33;             // time accumulator plus elapsed time
    localparam int DIV_HI    = ACC_W - N_W;    // dividend bits above the quotient
    localparam int PERIOD_W  = 18;
    localparam int REM_W     = PERIOD_W;       // remainder stays below the period
    localparam int FRAC_BITS = 24;             // running mean fraction bits
    localparam int COEF_W    = 15;
    localparam int Q_DEPTH   = 2;              // front to back queue depth
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 18'd5208;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 18'd250000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 18'd22675;
    localparam logic [COEF_W-1:0]   MEAN_COEF    = 15'd16777;

    // Commands
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_CAPTURE_ENABLE = 1'b0;
    localparam logic REG_SAMPLE_PERIOD  = 1'b1;

    // Sign codes of mono against the running mean
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_ABOVE = 2'd1;
    localparam logic [1:0] SIGN_BELOW = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [31:0]      elapsed_ns;
        logic             beeper_present;
        logic             beeper_level;
        logic [SMP_W-1:0] left_sample;
        logic [SMP_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic [15:0] samples_this_tick;
        logic [47:0] sample_count;
        logic [31:0] beep_changes;
        logic [31:0] mean_crossings;
        logic [15:0] min_left;
        logic [15:0] max_left;
        logic [15:0] min_right;
        logic [15:0] max_right;
        logic [47:0] sum_left;
        logic [47:0] sum_right;
        logic [62:0] sumsq_left;
        logic [62:0] sumsq_right;
    } t_out_item;

    // One classified transaction handed from front to back
    typedef struct packed {
        logic             restart;
        logic [N_W-1:0]   quot;
        logic [SMP_W-1:0] left;
        logic [SMP_W-1:0] right;
        logic [31:0]      toggles;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (&a) ? a : a + 32'd1;
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[48] ? {48{1'b1}} : sum[47:0];
    endfunction

    function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[63] ? {63{1'b1}} : sum[62:0];
    endfunction

endpackage

// ----- rtl/audio_capture_statistics.sv -----
// Running statistics of a sampled stereo mixer. Each input transaction is a tick
// (elapsed nanoseconds, optional beeper level, current left/right samples) or a
// restart that clears every statistic and the time accumulator; registers keep
// their values. With capture enabled a tick takes one output sample per whole
// sample period (clamped to 5208..250000 ns) and updates count, sums, sums of
// squares, extremes and mean-relative zero crossings; every transaction returns
// exactly one result with the current statistics. The front end takes restarts
// and ignored ticks in its idle state, settles a tick of zero or one sample in a
// check state, sends larger counts through a bit-serial divider and takes no new
// transaction before the last one is queued. The back end goes straight to output
// for restart, disabled or sample-free ticks, else runs its multiply and sum states
// and then running-mean updates of a product and an update state each: one per
// sample, ending early once the mean and its sign have settled. A two-entry queue
// between the two halves and an output register let each side stall on its own.
module audio_capture_statistics #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               i_in_valid,
    input  acs_pkg::t_in_item                  i_in_data,
    output logic                               o_in_stall,
    // result output
    output logic                               o_out_valid,
    output acs_pkg::t_out_item                 o_out_data,
    input  logic                               i_out_stall,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [acs_pkg::ADDR_W-1:0]         paddr,
    input  logic [acs_pkg::DATA_W-1:0]         pwdata,
    output logic [acs_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    logic                            r_cap_en;
    logic [acs_pkg::PERIOD_W-1:0]    r_period;

    logic                            w_push;
    logic                            w_pop;
    acs_pkg::t_q_entry               w_push_data;
    acs_pkg::t_q_entry               w_pop_data;
    acs_pkg::t_q_status              w_q_status;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en <= 1'b0;
            r_period <= acs_pkg::PERIOD_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                acs_pkg::REG_CAPTURE_ENABLE: r_cap_en <= pwdata[0];
                acs_pkg::REG_SAMPLE_PERIOD:  r_period <= pwdata[acs_pkg::PERIOD_W-1:0];
                default: begin
                    r_cap_en <= r_cap_en;
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[2])
            acs_pkg::REG_CAPTURE_ENABLE: prdata = acs_pkg::DATA_W'(r_cap_en);
            acs_pkg::REG_SAMPLE_PERIOD:  prdata = acs_pkg::DATA_W'(r_period);
            default:                     prdata = '0;
        endcase
    end

    acs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cap_en    (r_cap_en),
        .i_period    (r_period),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    acs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    acs_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_q_data    (w_pop_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- rtl/acs_queue.sv -----
module acs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  acs_pkg::t_q_entry i_push_data,
    input  logic              i_pop,
    output acs_pkg::t_q_entry o_pop_data,
    output acs_pkg::t_q_status o_status
);
    localparam int PTR_W = (acs_pkg::Q_DEPTH > 1) ? $clog2(acs_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(acs_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(acs_pkg::Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(acs_pkg::Q_DEPTH);

    acs_pkg::t_q_entry r_mem [acs_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/acs_front.sv -----
module acs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  acs_pkg::t_in_item                   i_in_data,
    output logic                                o_in_stall,
    input  logic                                i_cap_en,
    input  logic [acs_pkg::PERIOD_W-1:0]        i_period,
    input  acs_pkg::t_q_status                  i_q_status,
    output logic                                o_push,
    output acs_pkg::t_q_entry                   o_push_data
);
    localparam int CNT_W = $clog2(acs_pkg::N_W);
    localparam int PW    = acs_pkg::PERIOD_W;
    localparam int RW    = acs_pkg::REM_W;
    localparam int NW    = acs_pkg::N_W;
    localparam int AW    = acs_pkg::ACC_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CHK  = 3'b010,
        F_DIV  = 3'b100
    } t_fstate;

    t_fstate          r_state;
    logic [RW-1:0]    r_time_acc;
    logic             r_beep_seen;
    logic             r_beep_lvl;
    logic [31:0]      r_toggles;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_acc;
    logic [acs_pkg::SMP_W-1:0] r_l;
    logic [acs_pkg::SMP_W-1:0] r_r;
    logic [RW-1:0]    r_rem;
    logic [NW-1:0]    r_dq;

    logic [PW-1:0]    w_period;
    logic             w_accept;
    logic             w_restart;
    logic             w_lt1;
    logic             w_lt2;
    logic [AW-1:0]    w_sub;
    logic [RW:0]      w_trial;
    logic [RW:0]      w_trial_sub;
    logic             w_ge;
    logic [RW-1:0]    n_rem;
    logic [NW-1:0]    n_dq;
    logic             w_beep_toggle;

    // clamp the period to the supported rate range
    always_comb begin
        if (i_period < acs_pkg::PERIOD_MIN) begin
            w_period = acs_pkg::PERIOD_MIN;
        end else if (i_period > acs_pkg::PERIOD_MAX) begin
            w_period = acs_pkg::PERIOD_MAX;
        end else begin
            w_period = i_period;
        end
    end

    assign o_in_stall = !((r_state == F_IDLE) && !i_q_status.full);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_restart  = (i_in_data.cmd == acs_pkg::CMD_RESTART);

    // zero or one sample is resolved without the divider
    assign w_lt1 = (r_acc < AW'(w_period));
    assign w_lt2 = (r_acc < AW'({w_period, 1'b0}));
    assign w_sub = r_acc - AW'(w_period);

    // one restoring division step per cycle
    assign w_trial     = {r_rem, r_dq[NW-1]};
    assign w_ge        = (w_trial >= {1'b0, w_period});
    assign w_trial_sub = w_trial - {1'b0, w_period};
    assign n_rem       = w_ge ? w_trial_sub[RW-1:0] : w_trial[RW-1:0];
    assign n_dq        = {r_dq[NW-2:0], w_ge};

    assign w_beep_toggle = r_beep_seen && (i_in_data.beeper_level != r_beep_lvl);

    // transaction handed to the back end
    always_comb begin
        o_push_data.restart = 1'b0;
        o_push_data.quot    = '0;
        o_push_data.left    = r_l;
        o_push_data.right   = r_r;
        o_push_data.toggles = r_toggles;
        o_push              = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_push              = w_accept && (w_restart || !i_cap_en);
                o_push_data.restart = w_restart;
                o_push_data.left    = i_in_data.left_sample;
                o_push_data.right   = i_in_data.right_sample;
                o_push_data.toggles = w_restart ? '0 : r_toggles;
            end
            F_CHK: begin
                o_push           = w_lt2;
                o_push_data.quot = w_lt1 ? '0 : NW'(1);
            end
            F_DIV: begin
                o_push           = (r_cnt == '0);
                o_push_data.quot = n_dq;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // control state, time accumulator and beeper tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_time_acc  <= '0;
            r_beep_seen <= 1'b0;
            r_beep_lvl  <= 1'b0;
            r_toggles   <= '0;
            r_cnt       <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        if (w_restart) begin
                            r_time_acc  <= '0;
                            r_beep_seen <= 1'b0;
                            r_beep_lvl  <= 1'b0;
                            r_toggles   <= '0;
                        end else if (i_cap_en) begin
                            if (i_in_data.beeper_present) begin
                                if (w_beep_toggle) begin
                                    r_toggles <= acs_pkg::sat_inc32(r_toggles);
                                end
                                r_beep_lvl  <= i_in_data.beeper_level;
                                r_beep_seen <= 1'b1;
                            end
                            r_state <= F_CHK;
                        end
                    end
                end
                F_CHK: begin
                    if (w_lt1) begin
                        r_time_acc <= r_acc[RW-1:0];
                        r_state    <= F_IDLE;
                    end else if (w_lt2) begin
                        r_time_acc <= w_sub[RW-1:0];
                        r_state    <= F_IDLE;
                    end else begin
                        r_cnt   <= CNT_W'(NW - 1);
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_time_acc <= n_rem;
                        r_state    <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // item payload and divider datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == F_IDLE) && w_accept) begin
            r_acc <= AW'(r_time_acc) + AW'(i_in_data.elapsed_ns);
            r_l   <= i_in_data.left_sample;
            r_r   <= i_in_data.right_sample;
        end
        if (r_state == F_CHK) begin
            // top dividend bits are always below the smallest period
            r_rem <= RW'(r_acc[AW-1:NW]);
            r_dq  <= r_acc[NW-1:0];
        end else if (r_state == F_DIV) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

endmodule

// ----- rtl/acs_back.sv -----
`include "audio_capture_statistics_macros.svh"

module acs_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acs_pkg::t_q_status i_q_status,
    input  acs_pkg::t_q_entry  i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    output acs_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    localparam int EB     = (SAMPLE_BITS < acs_pkg::SMP_W) ? SAMPLE_BITS : acs_pkg::SMP_W;
    localparam int NW     = acs_pkg::N_W;
    localparam int FB     = acs_pkg::FRAC_BITS;
    localparam int MONO_W = EB + FB;
    localparam int PROD_W = MONO_W + acs_pkg::COEF_W;
    localparam int STEP_W = PROD_W + 1 - FB;
    localparam int LP_W   = EB + NW;
    localparam int SQ_W   = 2 * EB;
    localparam int SQP_W  = SQ_W + NW;

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_MUL1  = 7'b0000010,
        B_MUL2  = 7'b0000100,
        B_SQ    = 7'b0001000,
        B_MPROD = 7'b0010000,
        B_MUPD  = 7'b0100000,
        B_OUT   = 7'b1000000
    } t_bstate;

    t_bstate            r_state;
    logic [47:0]        r_count;
    logic [31:0]        r_cross;
    logic [1:0]         r_prev_sign;
    logic [MONO_W-1:0]  r_mean;
    logic [EB-1:0]      r_min_l;
    logic [EB-1:0]      r_max_l;
    logic [EB-1:0]      r_min_r;
    logic [EB-1:0]      r_max_r;
    logic [47:0]        r_sum_l;
    logic [47:0]        r_sum_r;
    logic [62:0]        r_sq_l;
    logic [62:0]        r_sq_r;
    logic [NW-1:0]      r_iter_left;
    logic               r_out_valid;

    logic [NW-1:0]      r_n;
    logic [EB-1:0]      r_l;
    logic [EB-1:0]      r_r;
    logic [31:0]        r_toggles;
    logic [LP_W-1:0]    r_lprod;
    logic [LP_W-1:0]    r_rprod;
    logic [SQ_W-1:0]    r_lsq;
    logic [SQ_W-1:0]    r_rsq;
    logic [SQP_W-1:0]   r_lsqp;
    logic [SQP_W-1:0]   r_rsqp;
    logic [PROD_W-1:0]  r_prod;
    logic               r_up;
    acs_pkg::t_out_item r_out_data;

    logic [EB:0]        w_lr;
    logic [MONO_W-1:0]  w_mono;
    logic               w_mono_ge;
    logic [MONO_W-1:0]  w_mag;
    logic [PROD_W:0]    w_rnd;
    logic [STEP_W-1:0]  w_step;
    logic [MONO_W-1:0]  n_mean;
    logic [1:0]         w_sign;
    logic               w_done;
    logic               w_out_free;

    assign o_pop       = (r_state == B_IDLE) && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // mono value (l + r) / 2 held exactly in mean fixed point
    assign w_lr      = (EB + 1)'(r_l) + (EB + 1)'(r_r);
    assign w_mono    = {w_lr, {(FB - 1){1'b0}}};
    assign w_mono_ge = (w_mono >= r_mean);
    assign w_mag     = w_mono_ge ? (w_mono - r_mean) : (r_mean - w_mono);

    // rounded step, ties away from zero since magnitude is unsigned
    assign w_rnd  = (PROD_W + 1)'(r_prod) + (PROD_W + 1)'(1 << (FB - 1));
    assign w_step = w_rnd[PROD_W:FB];
    assign n_mean = r_up ? (r_mean + MONO_W'(w_step)) : (r_mean - MONO_W'(w_step));
    assign w_sign = (w_mono > n_mean) ? acs_pkg::SIGN_ABOVE : acs_pkg::SIGN_BELOW;
    // stop once the mean has settled, or after the last sample of the tick
    assign w_done = ((n_mean == r_mean) && (w_sign == r_prev_sign))
                  || (r_iter_left == NW'(1));

    // statistics and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_cross     <= '0;
            r_prev_sign <= acs_pkg::SIGN_NONE;
            r_mean      <= '0;
            r_min_l     <= '1;
            r_max_l     <= '0;
            r_min_r     <= '1;
            r_max_r     <= '0;
            r_sum_l     <= '0;
            r_sum_r     <= '0;
            r_sq_l      <= '0;
            r_sq_r      <= '0;
            r_iter_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result handshake
            if ((r_state == B_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        if (i_q_data.restart) begin
                            r_count     <= '0;
                            r_cross     <= '0;
                            r_prev_sign <= acs_pkg::SIGN_NONE;
                            r_mean      <= '0;
                            r_min_l     <= '1;
                            r_max_l     <= '0;
                            r_min_r     <= '1;
                            r_max_r     <= '0;
                            r_sum_l     <= '0;
                            r_sum_r     <= '0;
                            r_sq_l      <= '0;
                            r_sq_r      <= '0;
                            r_state     <= B_OUT;
                        end else if (i_q_data.quot == '0) begin
                            r_state <= B_OUT;
                        end else begin
                            r_state <= B_MUL1;
                        end
                    end
                end
                B_MUL1: begin
                    r_count <= acs_pkg::sat_add48(r_count, 48'(r_n));
                    if (r_l < r_min_l) r_min_l <= r_l;
                    if (r_l > r_max_l) r_max_l <= r_l;
                    if (r_r < r_min_r) r_min_r <= r_r;
                    if (r_r > r_max_r) r_max_r <= r_r;
                    r_state <= B_MUL2;
                end
                B_MUL2: begin
                    r_sum_l <= acs_pkg::sat_add48(r_sum_l, 48'(r_lprod));
                    r_sum_r <= acs_pkg::sat_add48(r_sum_r, 48'(r_rprod));
                    r_state <= B_SQ;
                end
                B_SQ: begin
                    r_sq_l      <= acs_pkg::sat_add63(r_sq_l, 63'(r_lsqp));
                    r_sq_r      <= acs_pkg::sat_add63(r_sq_r, 63'(r_rsqp));
                    r_iter_left <= r_n;
                    r_state     <= B_MPROD;
                end
                B_MPROD: begin
                    r_state <= B_MUPD;
                end
                B_MUPD: begin
                    r_mean      <= n_mean;
                    r_prev_sign <= w_sign;
                    if ((r_prev_sign != acs_pkg::SIGN_NONE) && (w_sign != r_prev_sign)) begin
                        r_cross <= acs_pkg::sat_inc32(r_cross);
                    end
                    r_iter_left <= r_iter_left - NW'(1);
                    r_state     <= w_done ? B_OUT : B_MPROD;
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // transaction payload, products and result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_n       <= i_q_data.restart ? '0 : i_q_data.quot;
            r_l       <= i_q_data.left[EB-1:0];
            r_r       <= i_q_data.right[EB-1:0];
            r_toggles <= i_q_data.toggles;
        end
        if (r_state == B_MUL1) begin
            r_lprod <= LP_W'(r_l) * LP_W'(r_n);
            r_rprod <= LP_W'(r_r) * LP_W'(r_n);
            r_lsq   <= SQ_W'(r_l) * SQ_W'(r_l);
            r_rsq   <= SQ_W'(r_r) * SQ_W'(r_r);
        end
        if (r_state == B_MUL2) begin
            r_lsqp <= SQP_W'(r_lsq) * SQP_W'(r_n);
            r_rsqp <= SQP_W'(r_rsq) * SQP_W'(r_n);
        end
        if (r_state == B_MPROD) begin
            r_prod <= PROD_W'(w_mag) * PROD_W'(acs_pkg::MEAN_COEF);
            r_up   <= w_mono_ge;
        end
        if ((r_state == B_OUT) && w_out_free) begin
            r_out_data.samples_this_tick <= (|r_n[NW-1:16]) ? 16'hFFFF : r_n[15:0];
            r_out_data.sample_count      <= r_count;
            r_out_data.beep_changes      <= r_toggles;
            r_out_data.mean_crossings    <= r_cross;
            r_out_data.min_left          <= 16'(r_min_l);
            r_out_data.max_left          <= 16'(r_max_l);
            r_out_data.min_right         <= 16'(r_min_r);
            r_out_data.max_right         <= 16'(r_max_r);
            r_out_data.sum_left          <= r_sum_l;
            r_out_data.sum_right         <= r_sum_r;
            r_out_data.sumsq_left        <= r_sq_l;
            r_out_data.sumsq_right       <= r_sq_r;
        end
    end

    // checks
    `ACS_ASSERT_IMP(a_iter_live, r_state == B_MUPD, r_iter_left != '0, "no sample left")
    `ACS_ASSERT_IMP(a_order_l, r_count != '0, r_min_l <= r_max_l, "left extremes out of order")
    `ACS_ASSERT_IMP(a_order_r, r_count != '0, r_min_r <= r_max_r, "right extremes out of order")
    `ACS_ASSERT_IMP(a_no_sum, r_count == '0, (r_sum_l | r_sum_r) == '0, "sum without samples")
    `ACS_ASSERT_IMP(a_no_mean, r_count == '0, r_mean == '0, "mean without samples")

endmodule
